// File: src/otst_pkg.sv
// types, constants and codes shared by the one-shot timer slot table
// no dependencies
package otst_pkg;

   localparam int NUM_SLOTS_DEF = 32;
   localparam int RESULT_CAP    = 32;
   localparam int FCNT_W        = $clog2(RESULT_CAP + 1);

   typedef enum logic [1:0] {
      OP_SCHEDULE = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RES_OK              = 3'd0,
      RES_NO_FREE_SLOT    = 3'd1,
      RES_IGNORED_ZERO_ID = 3'd2,
      RES_NOT_FOUND       = 3'd3,
      RES_FIRED           = 3'd4
   } res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] timer_id;
      logic [30:0] delay;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] event_id;
      logic        last_event;
   } rsp_type;

   typedef struct packed {
      logic [31:0] timer_id;
      logic [31:0] due_time;
   } slot_type;

endpackage

// File: src/one_shot_timer_slot_table.sv
// top level of the one-shot timer slot table: sequencer, slot ram and result register
// depends on otst_pkg, otst_ram and otst_rsp_reg
//
// A table of NUM_SLOTS one-shot timers keyed by nonzero 32-bit ids, with a
// millisecond counter. Ids and due times live in a ram read once per cycle;
// the active bits are flip-flops cleared at reset. Schedule, cancel and tick
// each sweep the whole ram before the last result goes out, later when the
// result channel stalls. A schedule or cancel with id 0 skips the sweep; op 3
// is accepted and gives no result. Fired events of a tick are held back one
// slot so the final one can carry last_event; at most 32 fire per tick, the
// rest on later ticks.
module one_shot_timer_slot_table import otst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCNT_W = $clog2(NUM_SLOTS + 1);

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [31:0]            now_ff, now_in;
   logic [NUM_SLOTS-1:0]   act_ff, act_in;
   logic [SCNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;
   logic [FCNT_W-1:0]      fired_cnt_ff, fired_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [31:0]            pend_id_ff, pend_id_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   slot_type               ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   slot_type               ram_rdata;

   logic                   push_valid;
   rsp_type                push_data;
   logic                   can_push;

   logic [31:0]            slot_diff;
   logic                   slot_due;
   logic                   slot_act;
   logic                   ev_fire;
   logic                   stall;
   logic [IDX_W-1:0]       sched_idx;
   res_type                fin_res;

   otst_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   otst_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .can_push   (can_push),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign req_ready = (state_ff == ST_IDLE);

   assign slot_diff = ram_rdata.due_time - now_ff;
   assign slot_due  = (slot_diff == 32'd0) || slot_diff[31];
   assign slot_act  = act_ff[ev_idx_ff];
   assign ev_fire   = ev_valid_ff && (item_ff.op == OP_TICK) && slot_act && slot_due
                      && (fired_cnt_ff < FCNT_W'(RESULT_CAP));
   assign stall     = ev_fire && pend_valid_ff && !can_push;
   assign sched_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      if (item_ff.timer_id == 32'd0) begin
         fin_res = RES_IGNORED_ZERO_ID;
      end else if (item_ff.op == OP_CANCEL) begin
         fin_res = hit_ff ? RES_OK : RES_NOT_FOUND;
      end else begin
         fin_res = (hit_ff || free_ff) ? RES_OK : RES_NO_FREE_SLOT;
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      now_in        = now_ff;
      act_in        = act_ff;
      rd_cnt_in     = rd_cnt_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      fired_cnt_in  = fired_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = sched_idx;
      ram_wdata     = '{timer_id: item_ff.timer_id,
                        due_time: now_ff + {1'b0, item_ff.delay}};
      ram_raddr     = rd_cnt_ff[IDX_W-1:0];
      push_valid    = 1'b0;
      push_data     = '{event_res: fin_res, event_id: item_ff.timer_id, last_event: 1'b1};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               rd_cnt_in     = '0;
               ev_valid_in   = 1'b0;
               fired_cnt_in  = '0;
               pend_valid_in = 1'b0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               unique case (req_data.op) inside
                  OP_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_SCAN;
                  end
                  OP_SCHEDULE, OP_CANCEL: begin
                     state_in = (req_data.timer_id == 32'd0) ? ST_FINISH : ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (stall) begin
               ram_raddr = ev_idx_ff;
            end else begin
               if (rd_cnt_ff != SCNT_W'(NUM_SLOTS)) begin
                  ev_valid_in = 1'b1;
                  ev_idx_in   = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in   = rd_cnt_ff + 1'b1;
               end else begin
                  ev_valid_in = 1'b0;
                  if (!ev_valid_ff) begin
                     state_in = ST_FINISH;
                  end
               end
               if (ev_fire) begin
                  act_in[ev_idx_ff] = 1'b0;
                  fired_cnt_in      = fired_cnt_ff + 1'b1;
                  pend_valid_in     = 1'b1;
                  pend_id_in        = ram_rdata.timer_id;
                  if (pend_valid_ff) begin
                     push_valid = 1'b1;
                     push_data  = '{event_res: RES_FIRED, event_id: pend_id_ff,
                                    last_event: 1'b0};
                  end
               end
               if (ev_valid_ff && (item_ff.op != OP_TICK)) begin
                  if (slot_act && (ram_rdata.timer_id == item_ff.timer_id) && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = ev_idx_ff;
                  end
                  if (!slot_act && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = ev_idx_ff;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (item_ff.op == OP_TICK) begin
               push_data = '{event_res: RES_FIRED, event_id: pend_id_ff, last_event: 1'b1};
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (can_push) begin
                  push_valid    = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (can_push) begin
               push_valid = 1'b1;
               state_in   = ST_IDLE;
               if (item_ff.timer_id != 32'd0) begin
                  if ((item_ff.op == OP_CANCEL) && hit_ff) begin
                     act_in[hit_idx_ff] = 1'b0;
                  end
                  if ((item_ff.op == OP_SCHEDULE) && (hit_ff || free_ff)) begin
                     ram_we            = 1'b1;
                     act_in[sched_idx] = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         act_ff        <= '0;
         rd_cnt_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         fired_cnt_ff  <= '0;
         pend_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         act_ff        <= act_in;
         rd_cnt_ff     <= rd_cnt_in;
         ev_valid_ff   <= ev_valid_in;
         fired_cnt_ff  <= fired_cnt_in;
         pend_valid_ff <= pend_valid_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ev_idx_ff   <= ev_idx_in;
      pend_id_ff  <= pend_id_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // a tick transfer advances time by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.op == OP_TICK))
      |=> (now_ff == $past(now_ff) + 32'd1))
      else $error("tick did not advance time by one");

   // no fired event is left behind once the sequencer is back at rest
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_valid_ff && !ev_valid_ff))
      else $error("held fired event or scan stage live while idle");

   // never more fired events per tick than the result limit
   assert property (@(posedge clock) disable iff (reset)
      fired_cnt_ff <= FCNT_W'(RESULT_CAP))
      else $error("fired count past limit");

   // slot ram is only written when a schedule result goes out
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (push_valid && (state_ff == ST_FINISH) && (item_ff.op == OP_SCHEDULE)))
      else $error("slot ram written outside a schedule result");

endmodule

// File: src/otst_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module otst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/otst_rsp_reg.sv
// one-entry output register for the result channel
// depends on otst_pkg
module otst_rsp_reg import otst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    can_push,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    full_ff;
   rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (push_valid) begin
         full_ff <= 1'b1;
      end else if (rsp_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         data_ff <= push_data;
      end
   end

   assign can_push  = !full_ff || rsp_ready;
   assign rsp_valid = full_ff;
   assign rsp_data  = data_ff;

endmodule

// File: test/timer_table_checker.sv
// checker for the one-shot timer slot table: watches both channels, keeps its own
// copy of the slot table and compares every result transfer with the predicted event
// depends on otst_pkg
module timer_table_checker import otst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      events_checked
);

   logic        slot_on  [NUM_SLOTS];
   logic [31:0] slot_id  [NUM_SLOTS];
   logic [31:0] slot_due [NUM_SLOTS];
   logic [31:0] clock_ms;
   rsp_type     expected_events[$];

   task automatic add_event(input res_type res, input logic [31:0] id, input logic last);
      rsp_type ev;
      ev.event_res  = res;
      ev.event_id   = id;
      ev.last_event = last;
      expected_events.push_back(ev);
   endtask

   task automatic clear_slot(input int idx);
      slot_on[idx]  = 1'b0;
      slot_id[idx]  = '0;
      slot_due[idx] = '0;
   endtask

   function automatic logic slot_due_now(input int idx);
      logic [31:0] gap;
      gap = slot_due[idx] - clock_ms;
      return slot_on[idx] && (gap == '0 || gap[31]);
   endfunction

   task automatic apply_command(input req_type cmd);
      int hit;
      int free_idx;
      int due_count;
      int fired;
      hit       = -1;
      free_idx  = -1;
      due_count = 0;
      fired     = 0;
      case (cmd.op) inside
         OP_SCHEDULE, OP_CANCEL: begin
            if (cmd.timer_id == '0) begin
               add_event(RES_IGNORED_ZERO_ID, '0, 1'b1);
            end else begin
               // downward sweep leaves the lowest matching and lowest free index
               for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                  if (slot_on[i] && slot_id[i] == cmd.timer_id) hit = i;
                  if (!slot_on[i]) free_idx = i;
               end
               if (cmd.op == OP_CANCEL) begin
                  if (hit < 0) begin
                     add_event(RES_NOT_FOUND, cmd.timer_id, 1'b1);
                  end else begin
                     clear_slot(hit);
                     add_event(RES_OK, cmd.timer_id, 1'b1);
                  end
               end else begin
                  if (hit < 0) hit = free_idx;
                  if (hit < 0) begin
                     add_event(RES_NO_FREE_SLOT, cmd.timer_id, 1'b1);
                  end else begin
                     slot_on[hit]  = 1'b1;
                     slot_id[hit]  = cmd.timer_id;
                     slot_due[hit] = clock_ms + {1'b0, cmd.delay};
                     add_event(RES_OK, cmd.timer_id, 1'b1);
                  end
               end
            end
         end
         OP_TICK: begin
            clock_ms = clock_ms + 32'd1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_due_now(i) && due_count < RESULT_CAP) due_count++;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_due_now(i) && fired < due_count) begin
                  add_event(RES_FIRED, slot_id[i], fired == due_count - 1);
                  clear_slot(i);
                  fired++;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) clear_slot(i);
         clock_ms = '0;
         expected_events.delete();
         mismatches     = 0;
         events_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            events_checked++;
            if (expected_events.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: res %0d id %h last %0b",
                           rsp_data.event_res, rsp_data.event_id, rsp_data.last_event);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_res !== want.event_res || rsp_data.event_id !== want.event_id
                   || rsp_data.last_event !== want.last_event) begin
                  if (mismatches < 10) begin
                     $display("mismatch: expected res %0d id %h last %0b",
                              want.event_res, want.event_id, want.last_event);
                     $display("          got res %0d id %h last %0b",
                              rsp_data.event_res, rsp_data.event_id, rsp_data.last_event);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) apply_command(req_data);
      end
      outstanding <= expected_events.size();
   end

endmodule

// File: test/testbench.sv
// top of the one-shot timer slot table testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict
// depends on otst_pkg, one_shot_timer_slot_table and timer_table_checker
module testbench;
   import otst_pkg::*;

   localparam int          SLOTS          = NUM_SLOTS_DEF;
   localparam int          COMMANDS       = 180;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 2 * (SLOTS + 4);
   localparam logic [1:0]  OP_RESERVED    = 2'd3;
   localparam logic [30:0] DELAY_MAX      = 31'h7FFF_FFFF;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int events_checked;
   int stuck     = 0;
   int commands  = 0;
   int schedules = 0;
   int cancels   = 0;
   int ticks     = 0;
   int reserved  = 0;
   int fills     = 0;
   bit calm      = 1'b0;

   one_shot_timer_slot_table #(.NUM_SLOTS(SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   timer_table_checker #(.NUM_SLOTS(SLOTS)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .events_checked (events_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   task automatic send_cmd(input logic [1:0] op, input logic [31:0] id, input logic [30:0] delay);
      req_type item;
      item.op       = op;
      item.timer_id = id;
      item.delay    = delay;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      case (op)
         OP_SCHEDULE: schedules++;
         OP_CANCEL:   cancels++;
         OP_TICK:     ticks++;
         default:     reserved++;
      endcase
      if (op != OP_RESERVED) commands++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [30:0] pick_delay();
      case ($urandom_range(0, 9))
         0:       return DELAY_MAX;
         1:       return 31'($urandom);
         default: return 31'($urandom_range(0, 12));
      endcase
   endfunction

   // fill every slot, overflow it, then tick until the batch fires together
   task automatic fill_table();
      logic [30:0] delay;
      delay = 31'($urandom_range(0, 3));
      for (int k = 0; k <= SLOTS + 1; k++) send_cmd(OP_SCHEDULE, 32'h1000_0000 + k, delay);
      send_cmd(OP_SCHEDULE, 32'($urandom_range(1, 24)), pick_delay());
      repeat (int'(delay) + 1) send_cmd(OP_TICK, $urandom, 31'($urandom));
      fills++;
   endtask

   task automatic mixed_run();
      int pick;
      repeat (12) begin
         pick = $urandom_range(0, 19);
         if (pick < 7)       send_cmd(OP_SCHEDULE, pick_id(), pick_delay());
         else if (pick < 11) send_cmd(OP_CANCEL, pick_id(), 31'($urandom));
         else if (pick < 19) send_cmd(OP_TICK, $urandom, 31'($urandom));
         else                send_cmd(OP_RESERVED, $urandom, 31'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(OP_SCHEDULE, '0, 31'd5);
      send_cmd(OP_CANCEL, '0, '0);
      send_cmd(OP_RESERVED, 32'hFFFF_FFFF, DELAY_MAX);
      send_cmd(OP_CANCEL, 32'd5, '0);
      send_cmd(OP_SCHEDULE, 32'hFFFF_FFFF, '0);
      send_cmd(OP_SCHEDULE, 32'h0000_0001, DELAY_MAX);
      send_cmd(OP_SCHEDULE, 32'h8000_0000, 31'd2);
      send_cmd(OP_SCHEDULE, 32'hFFFF_FFFF, 31'd3);
      send_cmd(OP_TICK, '0, '0);
      send_cmd(OP_TICK, '0, '0);
      send_cmd(OP_CANCEL, 32'h0000_0001, '0);
      send_cmd(OP_CANCEL, 32'h0000_0001, '0);
      send_cmd(OP_TICK, 32'hFFFF_FFFF, DELAY_MAX);
      send_cmd(OP_TICK, '0, '0);
      drain();

      while (commands < COMMANDS) begin
         calm = (commands >= COMMANDS - 30);
         if (fills == 0 || ($urandom_range(0, 9) == 0 && fills < 3)) fill_table();
         else mixed_run();
         if (!calm && $urandom_range(0, 4) == 0) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("drove %0d commands: %0d schedule, %0d cancel, %0d tick, %0d unused op",
               commands, schedules, cancels, ticks, reserved);
      $display("%0d result transfers compared, %0d table fills, %0d mismatches",
               events_checked, fills, mismatches);
      if (mismatches == 0 && outstanding == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
